@@ rtl/evpfa_pkg.sv @@
// Package for the pointer frame accumulator: record type and code constants,
// the decoded-record struct and the packet struct. No dependencies.
`default_nettype none

package evpfa_pkg;

    // Record types
    localparam logic [15:0] TYPE_SYNC = 16'h0000;
    localparam logic [15:0] TYPE_KEY  = 16'h0001;
    localparam logic [15:0] TYPE_REL  = 16'h0002;
    localparam logic [15:0] TYPE_ABS  = 16'h0003;

    // Axis codes
    localparam logic [15:0] AXIS_X     = 16'h0000;
    localparam logic [15:0] AXIS_Y     = 16'h0001;
    localparam logic [15:0] AXIS_WHEEL = 16'h0008;

    // Mapped button code range
    localparam logic [15:0] BUTTON_FIRST = 16'h0110;
    localparam logic [15:0] BUTTON_LAST  = 16'h0114;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned BUTTONS_W = 5;
    localparam int unsigned BTN_IDX_W = 3;

    // Classification of one record
    typedef struct packed {
        logic                 is_sync;
        logic                 rel_x;
        logic                 rel_y;
        logic                 rel_scroll;
        logic                 abs_x;
        logic                 abs_y;
        logic                 button;
        logic [BTN_IDX_W-1:0] btn_idx;
        logic                 btn_level;
    } decode_t;

    // One output packet
    typedef struct packed {
        logic [BUTTONS_W-1:0] buttons;
        logic [VALUE_W-1:0]   dz;
        logic [VALUE_W-1:0]   dy;
        logic [VALUE_W-1:0]   dx;
    } packet_t;

endpackage

`default_nettype wire

@@ rtl/evpfa_decode.sv @@
// Record decoder: turns type, code and value into per-action strobes.
// Depends on evpfa_pkg.
`default_nettype none

module evpfa_decode (
    input  wire logic [15:0]                   func,
    input  wire logic [15:0]                   ev_code,
    input  wire logic [evpfa_pkg::VALUE_W-1:0] ev_value,
    output evpfa_pkg::decode_t                 dec
);

    logic        is_rel;
    logic        is_abs;
    logic        in_range;
    logic [15:0] btn_off;

    assign is_rel   = (func == evpfa_pkg::TYPE_REL);
    assign is_abs   = (func == evpfa_pkg::TYPE_ABS);
    assign in_range = (ev_code >= evpfa_pkg::BUTTON_FIRST) &&
                      (ev_code <= evpfa_pkg::BUTTON_LAST);
    assign btn_off  = ev_code - evpfa_pkg::BUTTON_FIRST;

    always_comb begin
        dec.is_sync    = (func == evpfa_pkg::TYPE_SYNC);
        dec.rel_x      = is_rel && (ev_code == evpfa_pkg::AXIS_X);
        dec.rel_y      = is_rel && (ev_code == evpfa_pkg::AXIS_Y);
        dec.rel_scroll = is_rel && (ev_code == evpfa_pkg::AXIS_WHEEL);
        dec.abs_x      = is_abs && (ev_code == evpfa_pkg::AXIS_X);
        dec.abs_y      = is_abs && (ev_code == evpfa_pkg::AXIS_Y);
        dec.button     = (func == evpfa_pkg::TYPE_KEY) && in_range;
        dec.btn_idx    = btn_off[evpfa_pkg::BTN_IDX_W-1:0];
        dec.btn_level  = |ev_value;
    end

endmodule

`default_nettype wire

@@ rtl/evpfa_core.sv @@
// Accumulator core: frame state, relative/absolute/button updates and
// packet build on sync. Depends on evpfa_pkg.
`default_nettype none

module evpfa_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          valid,
    input  wire evpfa_pkg::decode_t            dec,
    input  wire logic [evpfa_pkg::VALUE_W-1:0] value,
    input  wire logic                          slot_free,
    output logic                               fire,
    output logic                               emit,
    output evpfa_pkg::packet_t                 packet
);

    localparam int unsigned W  = evpfa_pkg::VALUE_W;
    localparam int unsigned BW = evpfa_pkg::BUTTONS_W;

    logic [W-1:0]  acc_x_reg, acc_x_next;
    logic [W-1:0]  acc_y_reg, acc_y_next;
    logic [W-1:0]  acc_wheel_reg, acc_wheel_next;
    logic [W-1:0]  base_x_reg, base_x_next;
    logic [W-1:0]  base_y_reg, base_y_next;
    logic [BW-1:0] held_reg, held_next;
    logic          active_reg, active_next;
    logic          seen_x_reg, seen_x_next;
    logic          seen_y_reg, seen_y_next;

    // Sync with activity produces a word; it needs a free output slot
    assign emit = valid && dec.is_sync && active_reg;
    assign fire = valid && (!emit || slot_free);

    assign packet.dx      = acc_x_reg;
    assign packet.dy      = acc_y_reg;
    assign packet.dz      = acc_wheel_reg;
    assign packet.buttons = held_reg;

    // Next-state for one record
    always_comb begin
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        acc_wheel_next = acc_wheel_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        held_next      = held_reg;
        active_next    = active_reg;
        seen_x_next    = seen_x_reg;
        seen_y_next    = seen_y_reg;
        if (dec.is_sync) begin
            if (active_reg) begin
                acc_x_next     = '0;
                acc_y_next     = '0;
                acc_wheel_next = '0;
                active_next    = 1'b0;
            end
        end else if (dec.rel_x) begin
            acc_x_next  = acc_x_reg + value;
            active_next = 1'b1;
        end else if (dec.rel_y) begin
            acc_y_next  = acc_y_reg + value;
            active_next = 1'b1;
        end else if (dec.rel_scroll) begin
            acc_wheel_next = acc_wheel_reg + value;
            active_next    = 1'b1;
        end else if (dec.abs_x) begin
            // first report only sets the baseline
            if (seen_x_reg) begin
                acc_x_next  = acc_x_reg + (value - base_x_reg);
                active_next = 1'b1;
            end
            seen_x_next = 1'b1;
            base_x_next = value;
        end else if (dec.abs_y) begin
            if (seen_y_reg) begin
                acc_y_next  = acc_y_reg + (value - base_y_reg);
                active_next = 1'b1;
            end
            seen_y_next = 1'b1;
            base_y_next = value;
        end else if (dec.button) begin
            held_next[dec.btn_idx] = dec.btn_level;
            active_next            = 1'b1;
        end
    end

    // State registers, updated only when a record is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_wheel_reg <= '0;
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            held_reg      <= '0;
            active_reg    <= 1'b0;
            seen_x_reg    <= 1'b0;
            seen_y_reg    <= 1'b0;
        end else if (fire) begin
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            acc_wheel_reg <= acc_wheel_next;
            base_x_reg    <= base_x_next;
            base_y_reg    <= base_y_next;
            held_reg      <= held_next;
            active_reg    <= active_next;
            seen_x_reg    <= seen_x_next;
            seen_y_reg    <= seen_y_next;
        end
    end

`ifndef SYNTH
    // A consumed sync leaves an empty frame behind
    a_sync_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && dec.is_sync |=> !active_reg && acc_x_reg == '0 &&
            acc_y_reg == '0 && acc_wheel_reg == '0)
        else $error("sync did not clear frame state");

    // Mapped relative and button records always mark activity
    a_rel_active: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (dec.rel_x || dec.rel_y || dec.rel_scroll || dec.button)
            |=> active_reg)
        else $error("activity not recorded");

    // Absolute X report establishes the baseline
    a_abs_x_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && dec.abs_x && !dec.is_sync |=> seen_x_reg && base_x_reg == $past(value))
        else $error("abs X baseline not set");

    // A word is never emitted without a free slot
    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit |-> slot_free)
        else $error("emit into occupied output slot");
`endif

endmodule

`default_nettype wire

@@ rtl/evpfa_out_reg.sv @@
// Output register for result words; holds a word until the receiver takes it.
// Depends on evpfa_pkg.
`default_nettype none

module evpfa_out_reg (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  wire evpfa_pkg::packet_t packet,
    output logic              slot_free,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output evpfa_pkg::packet_t m_packet
);

    logic               valid_reg;
    evpfa_pkg::packet_t data_reg;

    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_packet  = data_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= packet;
        end
    end

endmodule

`default_nettype wire

@@ rtl/evpfa_top_placeholder.sv @@
// Input register stage for evdev records, ahead of the decoder and core.
// Depends on evpfa_pkg.
`default_nettype none

module evpfa_top_placeholder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        advance,
    output logic             valid,
    output logic [15:0]      func,
    output logic [15:0]      ev_code,
    output logic [evpfa_pkg::VALUE_W-1:0] ev_value
);

    logic        valid_reg;
    logic [63:0] data_reg;
    logic        take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;
    assign valid    = valid_reg;
    assign func     = data_reg[15:0];
    assign ev_code  = data_reg[31:16];
    assign ev_value = data_reg[63:32];

    // Occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // Record payload
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/evdev_pointer_frame_accumulator.sv @@
// Pointer frame accumulator for evdev records.
// Receiving channel s_*: one record per word (type, code, signed value).
// Sending channel m_*: one packet (dx, dy, wheel, buttons) per sync record
// that closes a frame with pointer activity; other records give no word.
// Relative axes add, absolute axes add the change from the last report,
// buttons 0x110..0x114 keep a level mask that survives packets.
// A record accepted into the input register is processed by the core from
// there; its packet, if any, is loaded into the output register on m_*.
// Throughput: one record per cycle while no sync waits for the output slot,
// set by the single accumulate stage between the input and output registers.
// Reset (aresetn low, synchronous) clears all accumulators, baselines,
// button levels and both valid flags; the block is ready the cycle after.
// When the receiver stalls, a held packet stays on m_*; records keep
// flowing until a sync with activity needs the occupied output slot, and
// then s_tready drops until the packet is taken.
// Depends on evpfa_pkg, evpfa_top_placeholder, evpfa_decode, evpfa_core,
// evpfa_out_reg.
`default_nettype none

module evdev_pointer_frame_accumulator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] func, [31:16] ev_code, [63:32] ev_value
    input  wire logic [63:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] delta_x, [63:32] delta_y, [95:64] delta_wheel,
    // [100:96] button_mask, [103:101] zero
    output logic [103:0]      m_tdata
);

    logic                          rec_valid;
    logic [15:0]                   rec_func;
    logic [15:0]                   rec_code;
    logic [evpfa_pkg::VALUE_W-1:0] rec_value;
    logic                          fire;
    logic                          emit;
    logic                          slot_free;
    evpfa_pkg::decode_t            dec;
    evpfa_pkg::packet_t            packet;
    evpfa_pkg::packet_t            out_packet;

    // Input register
    evpfa_top_placeholder u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (fire),
        .valid    (rec_valid),
        .func     (rec_func),
        .ev_code  (rec_code),
        .ev_value (rec_value)
    );

    // Record classification
    evpfa_decode u_dec (
        .func     (rec_func),
        .ev_code  (rec_code),
        .ev_value (rec_value),
        .dec      (dec)
    );

    // Frame state
    evpfa_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid     (rec_valid),
        .dec       (dec),
        .value     (rec_value),
        .slot_free (slot_free),
        .fire      (fire),
        .emit      (emit),
        .packet    (packet)
    );

    // Output register
    evpfa_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && emit),
        .packet    (packet),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_packet  (out_packet)
    );

    assign m_tdata = {3'b000, out_packet.buttons, out_packet.dz,
                      out_packet.dy, out_packet.dx};

endmodule

`default_nettype wire

@@ verif/tb_evdev_pointer_frame_accumulator.sv @@
// Testbench for evdev_pointer_frame_accumulator: streams evdev records in, predicts
// each packet from a behavioral copy of the frame state, and checks every output word.
// Depends on evpfa_pkg (record types, axis and button codes, packet_t) and the RTL top.
`default_nettype none

module tb_evdev_pointer_frame_accumulator;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // [15:0] func, [31:16] ev_code, [63:32] ev_value
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [31:0] delta_x, [63:32] delta_y, [95:64] delta_wheel, [100:96] button_mask
    logic [103:0] m_tdata;

    // Idle and stall rates in percent, changed per phase
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;

    int unsigned records_sent = 0;
    int unsigned packets_checked = 0;
    int unsigned error_count = 0;

    // Behavioral copy of the frame state
    logic [31:0] sum_x, sum_y, sum_wheel;
    logic [4:0]  btn_levels;
    logic        moved;
    logic [31:0] prev_abs_x, prev_abs_y;
    logic        have_abs_x, have_abs_y;
    evpfa_pkg::packet_t pending_packets[$];

    evdev_pointer_frame_accumulator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: random backpressure, changed at the falling edge
    always @(negedge aclk) begin
        m_tready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
    end

    // Update the frame state for one accepted record; queue a packet on a busy sync
    task automatic predict_record(input logic [63:0] word);
        logic [15:0]        f;
        logic [15:0]        c;
        logic [31:0]        v;
        evpfa_pkg::packet_t p;
        int                 bit_idx;
        f = word[15:0];
        c = word[31:16];
        v = word[63:32];
        case (f)
            evpfa_pkg::TYPE_SYNC: begin
                if (moved) begin
                    p.dx = sum_x;
                    p.dy = sum_y;
                    p.dz = sum_wheel;
                    p.buttons = btn_levels;
                    pending_packets.push_back(p);
                    sum_x = '0;
                    sum_y = '0;
                    sum_wheel = '0;
                    moved = 1'b0;
                end
            end
            evpfa_pkg::TYPE_REL: begin
                if (c == evpfa_pkg::AXIS_X) begin
                    sum_x += v;
                    moved = 1'b1;
                end else if (c == evpfa_pkg::AXIS_Y) begin
                    sum_y += v;
                    moved = 1'b1;
                end else if (c == evpfa_pkg::AXIS_WHEEL) begin
                    sum_wheel += v;
                    moved = 1'b1;
                end
            end
            evpfa_pkg::TYPE_ABS: begin
                // first report on an axis only sets the baseline
                if (c == evpfa_pkg::AXIS_X) begin
                    if (have_abs_x) begin
                        sum_x += v - prev_abs_x;
                        moved = 1'b1;
                    end
                    have_abs_x = 1'b1;
                    prev_abs_x = v;
                end else if (c == evpfa_pkg::AXIS_Y) begin
                    if (have_abs_y) begin
                        sum_y += v - prev_abs_y;
                        moved = 1'b1;
                    end
                    have_abs_y = 1'b1;
                    prev_abs_y = v;
                end
            end
            evpfa_pkg::TYPE_KEY: begin
                if (c >= evpfa_pkg::BUTTON_FIRST && c <= evpfa_pkg::BUTTON_LAST) begin
                    bit_idx = int'(c - evpfa_pkg::BUTTON_FIRST);
                    btn_levels[bit_idx] = (v != 0);
                    moved = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_packet(input evpfa_pkg::packet_t got);
        evpfa_pkg::packet_t want;
        if (pending_packets.size() == 0) begin
            $error("unexpected packet: delta_x %0d delta_y %0d delta_wheel %0d buttons 'h%0h",
                   $signed(got.dx), $signed(got.dy), $signed(got.dz), got.buttons);
            error_count++;
        end else begin
            want = pending_packets.pop_front();
            if (got.dx !== want.dx) begin
                $error("delta_x: expected %0d, got %0d", $signed(want.dx), $signed(got.dx));
                error_count++;
            end
            if (got.dy !== want.dy) begin
                $error("delta_y: expected %0d, got %0d", $signed(want.dy), $signed(got.dy));
                error_count++;
            end
            if (got.dz !== want.dz) begin
                $error("delta_wheel: expected %0d, got %0d",
                       $signed(want.dz), $signed(got.dz));
                error_count++;
            end
            if (got.buttons !== want.buttons) begin
                $error("button_mask: expected 'h%0h, got 'h%0h", want.buttons, got.buttons);
                error_count++;
            end
        end
        packets_checked++;
    endtask

    // Checker and predictor: sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            // a packet leaving now can never come from a record accepted now
            if (m_tvalid && m_tready)
                check_packet(m_tdata[100:0]);
            if (s_tvalid && s_tready)
                predict_record(s_tdata);
        end
    end

    // Send one record; s_tvalid stays high afterwards until the next call decides
    task automatic send_record(input logic [15:0] f, input logic [15:0] c,
                               input logic [31:0] v);
        @(negedge aclk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, c, f};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        records_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4, 5: return $urandom;
            default: return $urandom_range(100) - 50;
        endcase
    endfunction

    // One record inside a frame: mostly pointer traffic, some noise
    task automatic send_random_record();
        int unsigned r;
        logic [15:0] axis;
        r = $urandom_range(99);
        if (r < 30) begin
            case ($urandom_range(2))
                0: axis = evpfa_pkg::AXIS_X;
                1: axis = evpfa_pkg::AXIS_Y;
                default: axis = evpfa_pkg::AXIS_WHEEL;
            endcase
            send_record(evpfa_pkg::TYPE_REL, axis, pick_value());
        end else if (r < 50) begin
            axis = $urandom_range(1) ? evpfa_pkg::AXIS_Y : evpfa_pkg::AXIS_X;
            send_record(evpfa_pkg::TYPE_ABS, axis, pick_value());
        end else if (r < 75) begin
            send_record(evpfa_pkg::TYPE_KEY,
                        evpfa_pkg::BUTTON_FIRST + 16'($urandom_range(4)),
                        $urandom_range(1) ? 32'h0 : pick_value());
        end else begin
            case ($urandom_range(4))
                0: send_record(16'($urandom), 16'($urandom), $urandom);
                1: send_record(evpfa_pkg::TYPE_KEY, 16'($urandom), $urandom);
                2: send_record(evpfa_pkg::TYPE_REL, 16'($urandom), $urandom);
                3: send_record(evpfa_pkg::TYPE_ABS, 16'($urandom), $urandom);
                default: send_record(evpfa_pkg::TYPE_SYNC, 16'($urandom), $urandom);
            endcase
        end
    endtask

    // Sync on an idle frame gives nothing
    task automatic test_empty_sync();
        send_record(evpfa_pkg::TYPE_SYNC, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // Relative axes, including wrap past the positive limit
    task automatic test_relative_axes();
        send_record(evpfa_pkg::TYPE_REL, evpfa_pkg::AXIS_X, 32'h7FFF_FFFF);
        send_record(evpfa_pkg::TYPE_REL, evpfa_pkg::AXIS_X, 32'h0000_0001);
        send_record(evpfa_pkg::TYPE_REL, evpfa_pkg::AXIS_Y, 32'h8000_0000);
        send_record(evpfa_pkg::TYPE_REL, evpfa_pkg::AXIS_WHEEL, 32'hFFFF_FFFF);
        send_record(evpfa_pkg::TYPE_REL, 16'hFFFF, 32'h1234_5678);
        send_record(evpfa_pkg::TYPE_SYNC, 16'h0, 32'h0);
    endtask

    // Absolute axes: baseline first, then differences that wrap
    task automatic test_absolute_axes();
        send_record(evpfa_pkg::TYPE_ABS, evpfa_pkg::AXIS_X, 32'd100);
        send_record(evpfa_pkg::TYPE_SYNC, 16'h0, 32'h0);
        send_record(evpfa_pkg::TYPE_ABS, evpfa_pkg::AXIS_X, 32'd40);
        send_record(evpfa_pkg::TYPE_ABS, evpfa_pkg::AXIS_Y, 32'h8000_0000);
        send_record(evpfa_pkg::TYPE_ABS, evpfa_pkg::AXIS_Y, 32'h7FFF_FFFF);
        send_record(evpfa_pkg::TYPE_ABS, 16'hFFFF, 32'hFFFF_FFFF);
        send_record(evpfa_pkg::TYPE_SYNC, 16'hA5A5, 32'h5A5A_5A5A);
    endtask

    // Button levels at both ends of the mapped range, neighbors ignored
    task automatic test_buttons();
        send_record(evpfa_pkg::TYPE_KEY, evpfa_pkg::BUTTON_FIRST, 32'd1);
        send_record(evpfa_pkg::TYPE_KEY, evpfa_pkg::BUTTON_LAST, 32'h8000_0000);
        send_record(evpfa_pkg::TYPE_KEY, evpfa_pkg::BUTTON_FIRST, 32'h0);
        send_record(evpfa_pkg::TYPE_KEY, evpfa_pkg::BUTTON_FIRST - 16'd1, 32'd1);
        send_record(evpfa_pkg::TYPE_KEY, evpfa_pkg::BUTTON_LAST + 16'd1, 32'd1);
        send_record(evpfa_pkg::TYPE_SYNC, 16'h0, 32'h0);
    endtask

    // Unknown types and keyboard keys do nothing; buttons survive the packet
    task automatic test_ignored_records();
        send_record(16'hFFFF, evpfa_pkg::AXIS_X, 32'd5);
        send_record(evpfa_pkg::TYPE_KEY, 16'h001E, 32'd1);
        send_record(evpfa_pkg::TYPE_SYNC, 16'h0, 32'h0);
        send_record(evpfa_pkg::TYPE_REL, evpfa_pkg::AXIS_X, 32'hFFFF_FFFF);
        send_record(evpfa_pkg::TYPE_SYNC, 16'h0, 32'h0);
    endtask

    // Random frames of up to six records closed by a sync
    task automatic test_random_frames(input int unsigned src_pct, input int unsigned snk_pct,
                                      input int unsigned count);
        int unsigned stop_at;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        stop_at = records_sent + count;
        while (records_sent < stop_at) begin
            repeat ($urandom_range(6)) send_random_record();
            send_record(evpfa_pkg::TYPE_SYNC, 16'($urandom), $urandom);
        end
    endtask

    initial begin
        sum_x = '0;
        sum_y = '0;
        sum_wheel = '0;
        btn_levels = '0;
        moved = 1'b0;
        prev_abs_x = '0;
        prev_abs_y = '0;
        have_abs_x = 1'b0;
        have_abs_y = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_sync();
        test_relative_axes();
        test_absolute_axes();
        test_buttons();
        test_ignored_records();

        test_random_frames(0, 0, 125);
        test_random_frames(55, 0, 125);
        test_random_frames(0, 55, 125);
        test_random_frames(25, 25, 125);

        // drain
        @(negedge aclk);
        s_tvalid <= 1'b0;
        snk_stall_pct = 0;
        while (pending_packets.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d records: directed cases, then random frames %s",
                 records_sent, "under four idle/stall mixes;");
        $display("checked %0d packets, %0d mismatches.", packets_checked, error_count);
        if (error_count == 0)
            $display("** evdev_pointer_frame_accumulator: PASSED **");
        else
            $display("** evdev_pointer_frame_accumulator: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout: %0d packets still pending.", pending_packets.size());
        $display("** evdev_pointer_frame_accumulator: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

@@ evdev_pointer_frame_accumulator.f @@
rtl/evpfa_pkg.sv
rtl/evpfa_decode.sv
rtl/evpfa_core.sv
rtl/evpfa_out_reg.sv
rtl/evpfa_top_placeholder.sv
rtl/evdev_pointer_frame_accumulator.sv
verif/tb_evdev_pointer_frame_accumulator.sv
